/* sv/rhc_pkg.sv */
package rhc_pkg;

  localparam int CNT_W = 16;
  localparam int DIFF_W = CNT_W + 1;
  localparam int HUE_W = 9;
  localparam int CLS_W = 2;
  localparam int NUM_W = 25;
  localparam int BASE_W = 9;

  localparam int FIFO_AW = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [CLS_W-1:0] CLS_RED = 2'd0;
  localparam logic [CLS_W-1:0] CLS_GREEN = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BLUE = 2'd2;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN = 2'd3;

  localparam logic [HUE_W-1:0] HUE_RED_LO = 9'd30;
  localparam logic [HUE_W-1:0] HUE_RED_HI = 9'd330;
  localparam logic [HUE_W-1:0] HUE_GREEN_LO = 9'd60;
  localparam logic [HUE_W-1:0] HUE_BLUE_LO = 9'd180;
  localparam logic [HUE_W-1:0] HUE_BLUE_HI = 9'd300;

  localparam logic [BASE_W-1:0] BASE_GREEN = 9'd120;
  localparam logic [BASE_W-1:0] BASE_BLUE = 9'd240;
  localparam logic [BASE_W-1:0] BASE_WRAP = 9'd360;
  localparam logic signed [NUM_W:0] SLOPE = 26'sd60;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] delta;
  } div_item_t;

  function automatic logic [CLS_W-1:0] hue_class(input logic [HUE_W-1:0] hue);
    logic [CLS_W-1:0] cls;
    if (hue < HUE_RED_LO || hue > HUE_RED_HI) begin
      cls = CLS_RED;
    end else if (hue >= HUE_GREEN_LO && hue < HUE_BLUE_LO) begin
      cls = CLS_GREEN;
    end else if (hue >= HUE_BLUE_LO && hue <= HUE_BLUE_HI) begin
      cls = CLS_BLUE;
    end else begin
      cls = CLS_UNKNOWN;
    end
    return cls;
  endfunction

endpackage

/* sv/rgb_hue_color_classifier.sv */
// channel | direction | ports
// --------+-----------+------------------------------------------------------
// in      | input     | in_valid, in_ready, in_red_count/green_count/blue_count
// out     | output    | out_valid, out_ready, out_hue_degrees, out_color_class
//
// One item per cycle sustained while the output is not stalled. The path is
// two front stages (sector, numerator), the 4-entry queue, nine
// restoring-divider stages (one quotient bit each) and an output register.
// rst_n is synchronous; it empties the pipeline and the queue.
// A stalled output backs up the divider stages and then the queue; the front
// keeps accepting until the queue and both front stages are full.
module rgb_hue_color_classifier import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CNT_W-1:0] in_red_count,
  input  logic [CNT_W-1:0] in_green_count,
  input  logic [CNT_W-1:0] in_blue_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HUE_W-1:0] out_hue_degrees,
  output logic [CLS_W-1:0] out_color_class
);

  logic      f_valid, f_ready;
  div_item_t f_item;
  logic      b_valid, b_ready;
  div_item_t b_item;

  rhc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_count   (in_red_count),
    .in_green_count (in_green_count),
    .in_blue_count  (in_blue_count),
    .q_valid        (f_valid),
    .q_ready        (f_ready),
    .q_item         (f_item)
  );

  rhc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  rhc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (b_valid),
    .q_ready         (b_ready),
    .q_item          (b_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hue_degrees (out_hue_degrees),
    .out_color_class (out_color_class)
  );

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_degrees < HUE_W'(360))
    else $error("hue out of range");

  a_red_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hue_degrees < HUE_RED_LO || out_hue_degrees > HUE_RED_HI)
      |-> out_color_class == CLS_RED)
    else $error("red hue misclassified");

  a_div_item: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid |-> b_item.delta != '0)
    else $error("zero divisor reached divider");
`endif

endmodule

/* sv/rhc_front.sv */
module rhc_front import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CNT_W-1:0] in_red_count,
  input  logic [CNT_W-1:0] in_green_count,
  input  logic [CNT_W-1:0] in_blue_count,
  output logic             q_valid,
  input  logic             q_ready,
  output div_item_t        q_item
);

  logic                     s1_v_r;
  sector_t                  s1_sec_r, s1_sec_nxt;
  logic [CNT_W-1:0]         s1_delta_r, s1_delta_nxt;
  logic signed [DIFF_W-1:0] s1_diff_r, s1_diff_nxt;

  logic                     s2_v_r;
  div_item_t                s2_item_r, s2_item_nxt;

  logic                     rdy1, rdy2;
  logic [CNT_W-1:0]         mx, mn, dlt;
  logic [BASE_W-1:0]        base;
  logic signed [NUM_W:0]    num_s;

  assign rdy2 = !s2_v_r || q_ready;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ready = rdy1;
  assign q_valid = s2_v_r;
  assign q_item = s2_item_r;

  // stage 1: sector, delta, signed channel difference
  always_comb begin
    if (in_red_count >= in_green_count && in_red_count >= in_blue_count) begin
      s1_sec_nxt = SEC_RED;
      mx = in_red_count;
      s1_diff_nxt = $signed({1'b0, in_green_count}) - $signed({1'b0, in_blue_count});
    end else if (in_green_count >= in_blue_count) begin
      s1_sec_nxt = SEC_GREEN;
      mx = in_green_count;
      s1_diff_nxt = $signed({1'b0, in_blue_count}) - $signed({1'b0, in_red_count});
    end else begin
      s1_sec_nxt = SEC_BLUE;
      mx = in_blue_count;
      s1_diff_nxt = $signed({1'b0, in_red_count}) - $signed({1'b0, in_green_count});
    end
    mn = in_red_count;
    if (in_green_count < mn) begin
      mn = in_green_count;
    end
    if (in_blue_count < mn) begin
      mn = in_blue_count;
    end
    dlt = mx - mn;
    // equal channels: numerator is zero, divide by one gives hue 0
    s1_delta_nxt = (dlt == '0) ? CNT_W'(1) : dlt;
  end

  // stage 2: numerator = base*delta + 60*diff
  always_comb begin
    unique case (s1_sec_r)
      SEC_RED:   base = s1_diff_r[DIFF_W-1] ? BASE_WRAP : '0;
      SEC_GREEN: base = BASE_GREEN;
      SEC_BLUE:  base = BASE_BLUE;
      default:   base = '0;
    endcase
    num_s = $signed({1'b0, NUM_W'(s1_delta_r) * NUM_W'(base)})
          + $signed((NUM_W+1)'(s1_diff_r)) * SLOPE;
    s2_item_nxt.num = num_s[NUM_W-1:0];
    s2_item_nxt.delta = s1_delta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_sec_r <= s1_sec_nxt;
      s1_delta_r <= s1_delta_nxt;
      s1_diff_r <= s1_diff_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

endmodule

/* sv/rhc_fifo.sv */
module rhc_fifo import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  div_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output div_item_t rd_item
);

  div_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign wr_ready = cnt_r != (FIFO_AW+1)'(FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item = mem_r[rd_ptr_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* sv/rhc_back.sv */
module rhc_back import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  div_item_t        q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HUE_W-1:0] out_hue_degrees,
  output logic [CLS_W-1:0] out_color_class
);

  localparam int QW = HUE_W;

  // one quotient bit per stage, msb first
  logic [NUM_W-1:0] rem_r [QW-1];
  logic [NUM_W-1:0] rem_nxt [QW-1];
  logic [CNT_W-1:0] dlt_r [QW-1];
  logic [QW-1:0]    q_r [QW];
  logic [QW-1:0]    q_nxt [QW];
  logic [QW-1:0]    v_r;
  logic             ov_r;
  logic [HUE_W-1:0] hue_r;
  logic [CLS_W-1:0] cls_r;

  logic [NUM_W-1:0] rin [QW];
  logic [CNT_W-1:0] din [QW];
  logic [QW-1:0]    qin [QW];
  logic [NUM_W-1:0] dvs [QW];
  logic [QW-1:0]    vin;
  logic [QW-1:0]    ge;
  logic [QW:0]      rdy;

  always_comb begin
    rin[0] = q_item.num;
    din[0] = q_item.delta;
    qin[0] = '0;
    vin[0] = q_valid;
    for (int k = 1; k < QW; k++) begin
      rin[k] = rem_r[k-1];
      din[k] = dlt_r[k-1];
      qin[k] = q_r[k-1];
      vin[k] = v_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      dvs[k] = NUM_W'(din[k]) << (QW - 1 - k);
      ge[k] = rin[k] >= dvs[k];
      q_nxt[k] = qin[k] | (QW'(ge[k]) << (QW - 1 - k));
    end
    for (int k = 0; k < QW - 1; k++) begin
      rem_nxt[k] = ge[k] ? rin[k] - dvs[k] : rin[k];
    end
  end

  always_comb begin
    rdy[QW] = !ov_r || out_ready;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign q_ready = rdy[0];
  assign out_valid = ov_r;
  assign out_hue_degrees = hue_r;
  assign out_color_class = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ov_r <= 1'b0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vin[k];
        end
      end
      if (rdy[QW]) begin
        ov_r <= v_r[QW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW - 1; k++) begin
      if (rdy[k] && vin[k]) begin
        rem_r[k] <= rem_nxt[k];
        dlt_r[k] <= din[k];
      end
    end
    for (int k = 0; k < QW; k++) begin
      if (rdy[k] && vin[k]) begin
        q_r[k] <= q_nxt[k];
      end
    end
    if (rdy[QW] && v_r[QW-1]) begin
      hue_r <= q_r[QW-1];
      cls_r <= hue_class(q_r[QW-1]);
    end
  end

endmodule

/* test/hue_class_checker.sv */
`timescale 1ns / 1ps

module hue_class_checker import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CNT_W-1:0] in_red_count,
  input  logic [CNT_W-1:0] in_green_count,
  input  logic [CNT_W-1:0] in_blue_count,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [HUE_W-1:0] out_hue_degrees,
  input  logic [CLS_W-1:0] out_color_class,
  output int               pending,
  output int               errors
);

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CLS_W-1:0] cls;
  } hue_result_t;

  hue_result_t expected_hues[$];

  // max with ties to red, then green; hue is 0 on equal channels
  function automatic logic [HUE_W-1:0] reading_hue(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] g,
                                                   input logic [CNT_W-1:0] b);
    int ri, gi, bi, hi, lo, span, num;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    span = hi - lo;
    if (span == 0) begin
      return '0;
    end
    if (hi == ri) begin
      num = 60 * (gi - bi);
      if (num < 0) num += 360 * span;
    end else if (hi == gi) begin
      num = 120 * span + 60 * (bi - ri);
    end else begin
      num = 240 * span + 60 * (ri - gi);
    end
    return HUE_W'(num / span);
  endfunction

  function automatic logic [CLS_W-1:0] hue_band(input logic [HUE_W-1:0] hue);
    if (hue < 30 || hue > 330) begin
      return CLS_RED;
    end else if (hue >= 60 && hue < 180) begin
      return CLS_GREEN;
    end else if (hue >= 180 && hue <= 300) begin
      return CLS_BLUE;
    end
    return CLS_UNKNOWN;
  endfunction

  always @(posedge clk) begin
    hue_result_t exp_res;
    if (!rst_n) begin
      pending <= 0;
      errors <= 0;
    end else begin
      if (in_valid && in_ready) begin
        exp_res.hue = reading_hue(in_red_count, in_green_count, in_blue_count);
        exp_res.cls = hue_band(exp_res.hue);
        expected_hues.push_back(exp_res);
      end
      if (out_valid && out_ready) begin
        if (expected_hues.size() == 0) begin
          $error("unexpected result: hue_degrees %0d color_class %0d",
                 out_hue_degrees, out_color_class);
          errors <= errors + 1;
        end else begin
          exp_res = expected_hues.pop_front();
          if (out_hue_degrees !== exp_res.hue || out_color_class !== exp_res.cls) begin
            if (out_hue_degrees !== exp_res.hue) begin
              $error("hue_degrees: expected %0d, got %0d", exp_res.hue, out_hue_degrees);
            end
            if (out_color_class !== exp_res.cls) begin
              $error("color_class: expected %0d, got %0d", exp_res.cls, out_color_class);
            end
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_hues.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import rhc_pkg::*;;

  localparam int RANDOM_READINGS = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RX_OPEN = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;

  typedef struct packed {
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] g;
    logic [CNT_W-1:0] b;
  } reading_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CNT_W-1:0] in_red_count = '0;
  logic [CNT_W-1:0] in_green_count = '0;
  logic [CNT_W-1:0] in_blue_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [HUE_W-1:0] out_hue_degrees;
  logic [CLS_W-1:0] out_color_class;
  int               pending;
  int               errors;
  int               cycles = 0;
  int               rx_mode = RX_OPEN;
  int               rx_left = 0;
  reading_t         directed[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_hue_color_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_count   (in_red_count),
    .in_green_count (in_green_count),
    .in_blue_count  (in_blue_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue_degrees(out_hue_degrees),
    .out_color_class(out_color_class)
  );

  hue_class_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_count   (in_red_count),
    .in_green_count (in_green_count),
    .in_blue_count  (in_blue_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue_degrees(out_hue_degrees),
    .out_color_class(out_color_class),
    .pending        (pending),
    .errors         (errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rgb_hue_color_classifier verification failed");
      $finish;
    end
  end

  // receiver: phases of open, random and sparse ready
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_OPEN, RX_SPARSE);
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [CNT_W-1:0] rand_count();
    return CNT_W'($urandom());
  endfunction

  function automatic reading_t rand_reading();
    reading_t rd;
    logic [CNT_W-1:0] v;
    rd.r = rand_count();
    rd.g = rand_count();
    rd.b = rand_count();
    v = rand_count();
    case ($urandom_range(0, 9))
      0: begin
        rd.r = CNT_W'($urandom_range(0, 15));
        rd.g = CNT_W'($urandom_range(0, 15));
        rd.b = CNT_W'($urandom_range(0, 15));
      end
      1: begin
        rd.r = v;
        rd.g = v;
        rd.b = v;
      end
      2: begin
        rd.r = v;
        rd.g = v;
      end
      3: begin
        rd.r = v;
        rd.b = v;
      end
      4: begin
        rd.g = v;
        rd.b = v;
      end
      5: begin
        rd.r = ($urandom_range(0, 1) == 1) ? '1 : '0;
        rd.g = ($urandom_range(0, 1) == 1) ? '1 : '0;
        rd.b = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      6: begin
        rd.g = rd.r - CNT_W'($urandom_range(0, 3));
        rd.b = rd.r - CNT_W'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return rd;
  endfunction

  task automatic send_reading(input reading_t rd);
    logic rdy;
    in_valid <= 1'b1;
    in_red_count <= rd.r;
    in_green_count <= rd.g;
    in_blue_count <= rd.b;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  initial begin
    int burst_left;
    int gap;
    directed.push_back('{16'd0, 16'd0, 16'd0});
    directed.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    directed.push_back('{16'd1234, 16'd1234, 16'd1234});
    directed.push_back('{16'hFFFF, 16'd0, 16'd0});
    directed.push_back('{16'd0, 16'hFFFF, 16'd0});
    directed.push_back('{16'd0, 16'd0, 16'hFFFF});
    directed.push_back('{16'hFFFF, 16'hFFFF, 16'd0});
    directed.push_back('{16'hFFFF, 16'd0, 16'hFFFF});
    directed.push_back('{16'd0, 16'hFFFF, 16'hFFFF});
    directed.push_back('{16'hFFFF, 16'd0, 16'd1});
    directed.push_back('{16'd120, 16'd58, 16'd0});
    directed.push_back('{16'd2, 16'd1, 16'd0});
    directed.push_back('{16'd60, 16'd59, 16'd0});
    directed.push_back('{16'd1, 16'd1, 16'd0});
    directed.push_back('{16'd0, 16'd60, 16'd59});
    directed.push_back('{16'd0, 16'd1, 16'd1});
    directed.push_back('{16'd1, 16'd0, 16'd1});
    directed.push_back('{16'd60, 16'd0, 16'd59});
    directed.push_back('{16'd2, 16'd0, 16'd1});
    directed.push_back('{16'd360, 16'd0, 16'd174});
    directed.push_back('{16'd5, 16'd9, 16'd300});
    directed.push_back('{16'hAAAA, 16'h5555, 16'h0F0F});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_reading(directed[i]);
    end

    burst_left = 0;
    for (int n = 0; n < RANDOM_READINGS; n++) begin
      if (n == RANDOM_READINGS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_reading(rand_reading());
      if (burst_left > 0) burst_left--;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("rgb_hue_color_classifier verification clean");
    end else begin
      $display("rgb_hue_color_classifier verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rhc_pkg.sv
sv/rhc_front.sv
sv/rhc_fifo.sv
sv/rhc_back.sv
sv/rgb_hue_color_classifier.sv
test/hue_class_checker.sv
test/tb_top.sv
